// ----- hw/rtl/ttc_pkg.sv -----
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared types and codes for the triangle type classifier.
// ----------------------------------------------------------------------------
package ttc_pkg;

  localparam int KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 2'd0,
    KIND_EQUI = 2'd1,
    KIND_ISO  = 2'd2,
    KIND_SCAL = 2'd3
  } kind_t;

endpackage

// ----- hw/rtl/ttc_in_if.sv -----
// ----------------------------------------------------------------------------
// ttc_in_if
// Input channel: three vertices per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ttc_in_if #(
  parameter int W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] ax;
  logic [W-1:0] ay;
  logic [W-1:0] bx;
  logic [W-1:0] by;
  logic [W-1:0] cx;
  logic [W-1:0] cy;

  modport source (output valid, ax, ay, bx, by, cx, cy, input ready);
  modport sink   (input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface

// ----- hw/rtl/ttc_out_if.sv -----
// ----------------------------------------------------------------------------
// ttc_out_if
// Result channel: triangle kind and three side lengths per transaction.
// ----------------------------------------------------------------------------
interface ttc_out_if #(
  parameter int W = 16
);
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [W:0] side_ab;
  logic [W:0] side_ac;
  logic [W:0] side_bc;

  modport source (output valid, kind, side_ab, side_ac, side_bc, input ready);
  modport sink   (input valid, kind, side_ab, side_ac, side_bc, output ready);
endinterface

// ----- hw/rtl/ttc_lane.sv -----
// ----------------------------------------------------------------------------
// ttc_lane
// One side length: absolute differences, squares, sum, then a pipelined
// floor square root that settles one result bit per stage.
// ----------------------------------------------------------------------------
module ttc_lane #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  logic         in_vld,
  input  logic [W-1:0] px,
  input  logic [W-1:0] py,
  input  logic [W-1:0] qx,
  input  logic [W-1:0] qy,
  output logic         out_vld,
  output logic [W:0]   side
);

  localparam int N  = W + 1;
  localparam int SW = 2 * W + 2;
  localparam int NV = N + 3;

  logic [NV-1:0]   vld_r;
  logic [W-1:0]    pxb, pyb, qxb, qyb;
  logic [W-1:0]    dx_nxt, dy_nxt;
  logic [W-1:0]    dx_r, dy_r;
  logic [2*W-1:0]  sqx_r, sqy_r;
  logic [SW-1:0]   sum_r;
  logic [SW-1:0]   v_r   [N];
  logic [SW-1:0]   res_r [N];

  // offset binary keeps the signed order as unsigned order
  assign pxb = {~px[W-1], px[W-2:0]};
  assign pyb = {~py[W-1], py[W-2:0]};
  assign qxb = {~qx[W-1], qx[W-2:0]};
  assign qyb = {~qy[W-1], qy[W-2:0]};

  assign dx_nxt = (pxb >= qxb) ? (pxb - qxb) : (qxb - pxb);
  assign dy_nxt = (pyb >= qyb) ? (pyb - qyb) : (qyb - pyb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NV-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      sqx_r <= (2*W)'(dx_r) * (2*W)'(dx_r);
      sqy_r <= (2*W)'(dy_r) * (2*W)'(dy_r);
      sum_r <= SW'(sqx_r) + SW'(sqy_r);
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_root
    localparam logic [SW-1:0] BITV = SW'(1) << (2 * (N - 1 - k));
    logic [SW-1:0] vin, rin, trial;

    if (k == 0) begin : g_first
      assign vin = sum_r;
      assign rin = '0;
    end else begin : g_next
      assign vin = v_r[k-1];
      assign rin = res_r[k-1];
    end

    assign trial = rin + BITV;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (vin >= trial) begin
          v_r[k]   <= vin - trial;
          res_r[k] <= (rin >> 1) + BITV;
        end else begin
          v_r[k]   <= vin;
          res_r[k] <= rin >> 1;
        end
      end
    end
  end

  assign out_vld = vld_r[NV-1];
  assign side    = res_r[N-1][W:0];

endmodule

// ----- hw/rtl/ttc_merge.sv -----
// ----------------------------------------------------------------------------
// ttc_merge
// Combines the three lane lengths: triangle inequality and kind decision.
// ----------------------------------------------------------------------------
module ttc_merge #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  logic [W:0]     l1,
  input  logic [W:0]     l2,
  input  logic [W:0]     l3,
  output logic           out_vld,
  output ttc_pkg::kind_t kind,
  output logic [W:0]     s1,
  output logic [W:0]     s2,
  output logic [W:0]     s3
);
  import ttc_pkg::*;

  logic       vld_r;
  kind_t      kind_r, kind_nxt;
  logic [W:0] s1_r, s2_r, s3_r;
  logic       tri_ok, all_eq, any_eq;

  always_comb begin
    tri_ok = ((W+2)'(l1) < (W+2)'(l2) + (W+2)'(l3)) &&
             ((W+2)'(l2) < (W+2)'(l1) + (W+2)'(l3)) &&
             ((W+2)'(l3) < (W+2)'(l1) + (W+2)'(l2));
    all_eq = (l1 == l2) && (l2 == l3);
    any_eq = (l1 == l2) || (l1 == l3) || (l2 == l3);
    if (!tri_ok) begin
      kind_nxt = KIND_NONE;
    end else if (all_eq) begin
      kind_nxt = KIND_EQUI;
    end else if (any_eq) begin
      kind_nxt = KIND_ISO;
    end else begin
      kind_nxt = KIND_SCAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r <= kind_nxt;
      s1_r   <= l1;
      s2_r   <= l2;
      s3_r   <= l3;
    end
  end

  assign out_vld = vld_r;
  assign kind    = kind_r;
  assign s1      = s1_r;
  assign s2      = s2_r;
  assign s3      = s3_r;

endmodule

// ----- hw/rtl/ttc_skid.sv -----
// ----------------------------------------------------------------------------
// ttc_skid
// Output register with one skid entry; upstream ready comes from a flop.
// ----------------------------------------------------------------------------
module ttc_skid #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_vld,
  output logic          up_rdy,
  input  logic [DW-1:0] up_data,
  output logic          dn_vld,
  input  logic          dn_rdy,
  output logic [DW-1:0] dn_data
);

  logic          dn_vld_r, sv_r;
  logic [DW-1:0] dn_data_r, sd_r;
  logic          push, load;

  assign up_rdy = !sv_r;
  assign push   = up_vld && !sv_r;
  assign load   = !dn_vld_r || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_vld_r <= 1'b0;
      sv_r     <= 1'b0;
    end else if (load) begin
      dn_vld_r <= sv_r || push;
      sv_r     <= 1'b0;
    end else if (push) begin
      sv_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dn_data_r <= sv_r ? sd_r : up_data;
    end
    if (!load && push) begin
      sd_r <= up_data;
    end
  end

  assign dn_vld  = dn_vld_r;
  assign dn_data = dn_data_r;

endmodule

// ----- hw/rtl/triangle_type_classify.sv -----
// ----------------------------------------------------------------------------
// triangle_type_classify
// Three vertices in, floor side lengths and triangle kind out.
//
//   channel | dir | payload                          | handshake
//   in_ch   | in  | ax ay bx by cx cy                | valid/ready
//   out_ch  | out | kind side_ab side_ac side_bc     | valid/ready
//
// one transaction per cycle while the pipeline advances; the square root pipeline
// in each lane settles one result bit per stage
// reset clears only the valid bits, no clearing pass
// out_ready low freezes the pipeline once the skid entry holds a result;
// in_ready is a flop and goes low only then
// ----------------------------------------------------------------------------
module triangle_type_classify #(
  parameter int COORD_WIDTH = 16
) (
  input logic      clk,
  input logic      rst_n,
  ttc_in_if.sink   in_ch,
  ttc_out_if.source out_ch
);
  import ttc_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = KIND_W + 3 * (W + 1);

  logic          adv;
  logic          vld_ab, vld_ac, vld_bc;
  logic [W:0]    l_ab, l_ac, l_bc;
  logic          m_vld;
  kind_t         m_kind;
  logic [W:0]    m_ab, m_ac, m_bc;
  logic [DW-1:0] m_data, o_data;

  ttc_lane #(.W(W)) u_lane_ab (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(in_ch.valid),
    .px(in_ch.ax), .py(in_ch.ay), .qx(in_ch.bx), .qy(in_ch.by),
    .out_vld(vld_ab), .side(l_ab)
  );

  ttc_lane #(.W(W)) u_lane_ac (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(in_ch.valid),
    .px(in_ch.ax), .py(in_ch.ay), .qx(in_ch.cx), .qy(in_ch.cy),
    .out_vld(vld_ac), .side(l_ac)
  );

  ttc_lane #(.W(W)) u_lane_bc (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(in_ch.valid),
    .px(in_ch.bx), .py(in_ch.by), .qx(in_ch.cx), .qy(in_ch.cy),
    .out_vld(vld_bc), .side(l_bc)
  );

  ttc_merge #(.W(W)) u_merge (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(vld_ab && vld_ac && vld_bc),
    .l1(l_ab), .l2(l_ac), .l3(l_bc),
    .out_vld(m_vld), .kind(m_kind), .s1(m_ab), .s2(m_ac), .s3(m_bc)
  );

  assign m_data = {m_kind, m_ab, m_ac, m_bc};

  ttc_skid #(.DW(DW)) u_skid (
    .clk(clk), .rst_n(rst_n),
    .up_vld(m_vld), .up_rdy(adv), .up_data(m_data),
    .dn_vld(out_ch.valid), .dn_rdy(out_ch.ready), .dn_data(o_data)
  );

  assign in_ch.ready    = adv;
  assign out_ch.kind    = o_data[DW-1 -: KIND_W];
  assign out_ch.side_ab = o_data[3*(W+1)-1 -: W+1];
  assign out_ch.side_ac = o_data[2*(W+1)-1 -: W+1];
  assign out_ch.side_bc = o_data[W:0];

endmodule

// ----- hw/rtl/ttc_check.sv -----
// ----------------------------------------------------------------------------
// ttc_check
// Port-level checks for the triangle type classifier, bound to the top level.
// ----------------------------------------------------------------------------
module ttc_check #(
  parameter int W = 16
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [W:0] out_side_ab,
  input logic [W:0] out_side_ac,
  input logic [W:0] out_side_bc
);
  import ttc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_equi_sides: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_EQUI) |->
      (out_side_ab == out_side_ac) && (out_side_ac == out_side_bc))
    else $error("equilateral with unequal sides");

  a_tri_ineq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_NONE) |->
      ((W+2)'(out_side_ab) < (W+2)'(out_side_ac) + (W+2)'(out_side_bc)) &&
      ((W+2)'(out_side_bc) < (W+2)'(out_side_ab) + (W+2)'(out_side_ac)))
    else $error("triangle kind without strict inequality");

  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stalled without output backpressure");

endmodule

bind triangle_type_classify ttc_check #(.W(COORD_WIDTH)) u_ttc_check (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_kind(out_ch.kind),
  .out_side_ab(out_ch.side_ab),
  .out_side_ac(out_ch.side_ac),
  .out_side_bc(out_ch.side_bc)
);
